// ===== rtl/fdsa_pkg.sv =====
`timescale 1ns / 1ps
package fdsa_pkg;

	typedef enum logic [4:0] {
		CMD_PUSH    = 5'd0,
		CMD_DROP    = 5'd1,
		CMD_DUP     = 5'd2,
		CMD_SWAP    = 5'd3,
		CMD_ROT     = 5'd4,
		CMD_OVER    = 5'd5,
		CMD_ADD     = 5'd6,
		CMD_SUB     = 5'd7,
		CMD_MUL     = 5'd8,
		CMD_DIV     = 5'd9,
		CMD_MOD     = 5'd10,
		CMD_INC     = 5'd11,
		CMD_DEC     = 5'd12,
		CMD_EQ      = 5'd13,
		CMD_LT      = 5'd14,
		CMD_GT      = 5'd15,
		CMD_ZEQ     = 5'd16,
		CMD_FETCH   = 5'd17,
		CMD_STORE   = 5'd18,
		CMD_CFETCH  = 5'd19,
		CMD_CSTORE  = 5'd20,
		CMD_ZBRANCH = 5'd21
	} cmd_t;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_UNDER = 3'd1;
	localparam logic [2:0] ST_OVER  = 3'd2;
	localparam logic [2:0] ST_DIVZ  = 3'd3;
	localparam logic [2:0] ST_OOB   = 3'd4;

	typedef struct packed {
		logic [4:0]  command;
		logic [31:0] push_value;
	} cmd_word_t;

	typedef struct packed {
		logic [31:0] top_value;
		logic [6:0]  stack_depth;
		logic [2:0]  status;
		logic        branch_taken;
	} res_word_t;

endpackage

// ===== rtl/forth_data_stack_alu_top.sv =====
// Forth data-stack unit: one command word in, one result word out (new top of stack, depth,
// status, zero-branch flag). Stack cells live in a one-port-read, one-port-write RAM with a
// cached top cell; the dictionary is a byte-wide RAM. A command passes through these steps:
// accept, stack-RAM reads for the second and third cells (states RD1, RD2, RD3), execute,
// one write-back per changed cell (up to three for rot) plus a closing step, and loading the
// output register, which waits while an earlier result is still stalled. div and mod add a
// wait for the bit-serial divider; fetch and cfetch add byte reads, and store and cstore
// byte writes, on the dictionary port. After reset the dictionary is zeroed, one byte a
// cycle, and no command is accepted until that pass ends.
`timescale 1ns / 1ps
module forth_data_stack_alu_top import fdsa_pkg::*; #(
	parameter int STACK_DEPTH = 64,
	parameter int DICT_BYTES  = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(DICT_BYTES);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD1, S_RD2, S_RD3, S_EXEC, S_DIV, S_FRD, S_FEND, S_FWR, S_WB, S_FIN
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [31:0]     pv_q;
	logic [SPW-1:0]  sp_q;
	logic [31:0]     top_q;
	logic [31:0]     sec_q;
	logic [31:0]     thd_q;
	logic [2:0]      st_q;
	logic            br_q;
	logic [SAW-1:0]  wa_q [3];
	logic [31:0]     wd_q [3];
	logic [1:0]      wn_q;
	logic [1:0]      wi_q;
	logic [2:0]      k_q;
	logic [2:0]      nb_q;
	logic [AW-1:0]   da_q;
	logic [31:0]     fval_q;
	logic [AW-1:0]   clr_q;
	res_word_t       out_q;
	logic            out_valid_q;

	logic            full, lt1, lt2, lt3;
	logic [SAW-1:0]  a_sp0, a_m1, a_m2, a_m3;
	logic [31:0]     prod, alu_r;
	logic            fe_ok, cf_ok;
	logic [1:0]      kb;
	logic            stk_we;
	logic [SAW-1:0]  stk_raddr;
	logic [31:0]     stk_rdata;
	logic            dict_we;
	logic [AW-1:0]   dict_waddr, dict_raddr;
	logic [7:0]      dict_wdata, dict_rdata;
	logic            div_start, div_done;
	logic [31:0]     div_q, div_r;

	assign full  = sp_q >= SPW'(STACK_DEPTH);
	assign lt1   = sp_q == '0;
	assign lt2   = sp_q < SPW'(2);
	assign lt3   = sp_q < SPW'(3);
	assign a_sp0 = SAW'(sp_q);
	assign a_m1  = SAW'(sp_q - SPW'(1));
	assign a_m2  = SAW'(sp_q - SPW'(2));
	assign a_m3  = SAW'(sp_q - SPW'(3));
	assign prod  = sec_q * top_q;
	assign fe_ok = ({1'b0, top_q} + 33'd4) <= 33'(DICT_BYTES);
	assign cf_ok = top_q < 32'(DICT_BYTES);
	assign kb    = 2'(k_q - 3'd1);

	always_comb begin
		case (cmd_q)
			CMD_ADD:  alu_r = sec_q + top_q;
			CMD_SUB:  alu_r = sec_q - top_q;
			CMD_MUL:  alu_r = prod;
			CMD_INC:  alu_r = top_q + 32'd1;
			CMD_DEC:  alu_r = top_q - 32'd1;
			CMD_EQ:   alu_r = {31'd0, sec_q == top_q};
			CMD_LT:   alu_r = {31'd0, sec_q < top_q};
			CMD_GT:   alu_r = {31'd0, sec_q > top_q};
			CMD_ZEQ:  alu_r = {31'd0, top_q == 32'd0};
			default:  alu_r = '0;
		endcase
	end

	assign stk_we     = (state_q == S_WB) && (wi_q < wn_q);
	assign stk_raddr  = (state_q == S_RD2) ? a_m3 : a_m2;
	assign dict_we    = (state_q == S_CLR) || (state_q == S_FWR);
	assign dict_raddr = da_q + AW'(k_q);
	assign dict_waddr = (state_q == S_CLR) ? clr_q : dict_raddr;
	assign dict_wdata = (state_q == S_CLR) ? 8'd0 : fval_q[k_q[1:0]*8 +: 8];
	assign div_start  = (state_q == S_EXEC) && (cmd_q == CMD_DIV || cmd_q == CMD_MOD)
		&& !lt2 && (top_q != 32'd0);

	fdsa_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(wa_q[wi_q]), .wdata(wd_q[wi_q]),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	fdsa_ram #(.WIDTH(8), .DEPTH(DICT_BYTES)) u_dict (
		.clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(dict_wdata),
		.raddr(dict_raddr), .rdata(dict_rdata)
	);

	fdsa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sec_q), .divisor(top_q),
		.quotient(div_q), .remainder(div_r), .done(div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			sp_q        <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			wn_q        <= '0;
			wi_q        <= '0;
			k_q         <= '0;
		end else begin
			if (out_valid_q && !res_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DICT_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd_t'(cmd_word.command);
						pv_q    <= cmd_word.push_value;
						st_q    <= ST_OK;
						br_q    <= 1'b0;
						wn_q    <= '0;
						wi_q    <= '0;
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: begin
					sec_q   <= stk_rdata;
					state_q <= S_RD3;
				end
				S_RD3: begin
					thd_q   <= stk_rdata;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_WB;
					case (cmd_q)
						CMD_PUSH: begin
							if (full) st_q <= ST_OVER;
							else begin
								wa_q[0] <= a_sp0; wd_q[0] <= pv_q; wn_q <= 2'd1;
								top_q <= pv_q; sp_q <= sp_q + SPW'(1);
							end
						end
						CMD_DROP: begin
							if (lt1) st_q <= ST_UNDER;
							else begin
								top_q <= sec_q; sp_q <= sp_q - SPW'(1);
							end
						end
						CMD_DUP: begin
							if (lt1) st_q <= ST_UNDER;
							else if (full) st_q <= ST_OVER;
							else begin
								wa_q[0] <= a_sp0; wd_q[0] <= top_q; wn_q <= 2'd1;
								sp_q <= sp_q + SPW'(1);
							end
						end
						CMD_SWAP: begin
							if (lt2) st_q <= ST_UNDER;
							else begin
								wa_q[0] <= a_m1; wd_q[0] <= sec_q;
								wa_q[1] <= a_m2; wd_q[1] <= top_q;
								wn_q <= 2'd2; top_q <= sec_q;
							end
						end
						CMD_ROT: begin
							if (lt3) st_q <= ST_UNDER;
							else begin
								wa_q[0] <= a_m3; wd_q[0] <= sec_q;
								wa_q[1] <= a_m2; wd_q[1] <= top_q;
								wa_q[2] <= a_m1; wd_q[2] <= thd_q;
								wn_q <= 2'd3; top_q <= thd_q;
							end
						end
						CMD_OVER: begin
							if (lt2) st_q <= ST_UNDER;
							else if (full) st_q <= ST_OVER;
							else begin
								wa_q[0] <= a_sp0; wd_q[0] <= sec_q; wn_q <= 2'd1;
								top_q <= sec_q; sp_q <= sp_q + SPW'(1);
							end
						end
						CMD_ADD, CMD_SUB, CMD_MUL: begin
							if (lt2) st_q <= ST_UNDER;
							else begin
								wa_q[0] <= a_m2; wd_q[0] <= alu_r; wn_q <= 2'd1;
								top_q <= alu_r; sp_q <= sp_q - SPW'(1);
							end
						end
						CMD_DIV, CMD_MOD: begin
							if (lt2) st_q <= ST_UNDER;
							else if (top_q == 32'd0) begin
								st_q <= ST_DIVZ;
								wa_q[0] <= a_m2; wd_q[0] <= '0; wn_q <= 2'd1;
								top_q <= '0; sp_q <= sp_q - SPW'(1);
							end else begin
								state_q <= S_DIV;
							end
						end
						CMD_INC, CMD_DEC, CMD_ZEQ: begin
							if (lt1) begin
								if (cmd_q == CMD_ZEQ) begin
									wa_q[0] <= a_sp0; wd_q[0] <= '0; wn_q <= 2'd1;
									top_q <= '0; sp_q <= sp_q + SPW'(1);
								end
								st_q <= ST_UNDER;
							end else begin
								wa_q[0] <= a_m1; wd_q[0] <= alu_r; wn_q <= 2'd1;
								top_q <= alu_r;
							end
						end
						CMD_EQ, CMD_LT, CMD_GT: begin
							if (lt2) begin
								st_q <= ST_UNDER;
								wa_q[0] <= a_sp0; wd_q[0] <= '0; wn_q <= 2'd1;
								top_q <= '0; sp_q <= sp_q + SPW'(1);
							end else begin
								wa_q[0] <= a_m2; wd_q[0] <= alu_r; wn_q <= 2'd1;
								top_q <= alu_r; sp_q <= sp_q - SPW'(1);
							end
						end
						CMD_FETCH, CMD_CFETCH: begin
							if (lt1) begin
								st_q <= ST_UNDER;
								wa_q[0] <= a_sp0; wd_q[0] <= '0; wn_q <= 2'd1;
								top_q <= '0; sp_q <= sp_q + SPW'(1);
							end else if ((cmd_q == CMD_FETCH) ? fe_ok : cf_ok) begin
								da_q    <= top_q[AW-1:0];
								k_q     <= '0;
								nb_q    <= (cmd_q == CMD_FETCH) ? 3'd4 : 3'd1;
								fval_q  <= '0;
								state_q <= S_FRD;
							end else begin
								st_q <= ST_OOB;
								wa_q[0] <= a_m1; wd_q[0] <= '0; wn_q <= 2'd1;
								top_q <= '0;
							end
						end
						CMD_STORE, CMD_CSTORE: begin
							if (lt2) st_q <= ST_UNDER;
							else begin
								top_q <= thd_q; sp_q <= sp_q - SPW'(2);
								if ((cmd_q == CMD_STORE) ? fe_ok : cf_ok) begin
									da_q    <= top_q[AW-1:0];
									k_q     <= '0;
									nb_q    <= (cmd_q == CMD_STORE) ? 3'd4 : 3'd1;
									fval_q  <= sec_q;
									state_q <= S_FWR;
								end else begin
									st_q <= ST_OOB;
								end
							end
						end
						CMD_ZBRANCH: begin
							if (lt1) st_q <= ST_UNDER;
							else begin
								br_q <= top_q == 32'd0;
								top_q <= sec_q; sp_q <= sp_q - SPW'(1);
							end
						end
						default: ;
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						wa_q[0] <= a_m2;
						wd_q[0] <= (cmd_q == CMD_MOD) ? div_r : div_q;
						wn_q    <= 2'd1;
						top_q   <= (cmd_q == CMD_MOD) ? div_r : div_q;
						sp_q    <= sp_q - SPW'(1);
						state_q <= S_WB;
					end
				end
				S_FRD: begin
					if (k_q != '0) begin
						fval_q[kb*8 +: 8] <= dict_rdata;
					end
					k_q <= k_q + 3'd1;
					if (k_q == nb_q) begin
						state_q <= S_FEND;
					end
				end
				S_FEND: begin
					wa_q[0] <= a_m1; wd_q[0] <= fval_q; wn_q <= 2'd1;
					top_q   <= fval_q;
					state_q <= S_WB;
				end
				S_FWR: begin
					k_q <= k_q + 3'd1;
					if (k_q == nb_q - 3'd1) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (wi_q < wn_q) wi_q <= wi_q + 2'd1;
					else state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !res_stall) begin
						out_q.top_value    <= lt1 ? 32'd0 : top_q;
						out_q.stack_depth  <= 7'(sp_q);
						out_q.status       <= st_q;
						out_q.branch_taken <= br_q;
						out_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd_stall = state_q != S_IDLE;
	assign res_valid = out_valid_q;
	assign res_word  = out_q;

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV) else $error("divider finished outside divide");

	a_no_wb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_stall |-> !stk_we && !dict_we) else $error("memory write while idle");

	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> state_q == S_RD1) else $error("accept did not start");

endmodule

// ===== rtl/fdsa_ram.sv =====
`timescale 1ns / 1ps
module fdsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/fdsa_div.sv =====
`timescale 1ns / 1ps
module fdsa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic [31:0] remainder,
	output logic        done
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// ===== tb/forth_data_stack_alu_checker.sv =====
`timescale 1ns / 1ps
module forth_data_stack_alu_checker import fdsa_pkg::*; #(
	parameter int STACK_DEPTH = 64,
	parameter int DICT_BYTES  = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_stall,
	input  cmd_word_t cmd_word,
	input  logic      res_valid,
	input  logic      res_stall,
	input  res_word_t res_word,
	output int        fail_count,
	output int        pending_count
);

	logic [31:0] cells [STACK_DEPTH];
	int          depth;
	logic [7:0]  dict [DICT_BYTES];
	res_word_t   expected_results [$];

	assign pending_count = expected_results.size();

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		fail_count++;
	endtask

	function automatic void push_cell(input logic [31:0] v);
		cells[depth] = v;
		depth++;
	endfunction

	function automatic logic [31:0] pop_cell();
		depth--;
		return cells[depth];
	endfunction

	function automatic res_word_t execute_command(input cmd_word_t w);
		res_word_t   r;
		logic [2:0]  st;
		logic        br;
		logic [31:0] a, b, c;
		logic        full;
		st = ST_OK;
		br = 1'b0;
		full = depth >= STACK_DEPTH;
		case (w.command)
			CMD_PUSH: if (full) st = ST_OVER; else push_cell(w.push_value);
			CMD_DROP: if (depth < 1) st = ST_UNDER; else void'(pop_cell());
			CMD_DUP: begin
				if (depth < 1) st = ST_UNDER;
				else if (full) st = ST_OVER;
				else push_cell(cells[depth-1]);
			end
			CMD_SWAP: begin
				if (depth < 2) st = ST_UNDER;
				else begin
					a = cells[depth-1];
					cells[depth-1] = cells[depth-2];
					cells[depth-2] = a;
				end
			end
			CMD_ROT: begin
				if (depth < 3) st = ST_UNDER;
				else begin
					a = cells[depth-3];
					cells[depth-3] = cells[depth-2];
					cells[depth-2] = cells[depth-1];
					cells[depth-1] = a;
				end
			end
			CMD_OVER: begin
				if (depth < 2) st = ST_UNDER;
				else if (full) st = ST_OVER;
				else push_cell(cells[depth-2]);
			end
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_EQ, CMD_LT, CMD_GT: begin
				if (depth < 2) begin
					st = ST_UNDER;
					if (w.command inside {CMD_EQ, CMD_LT, CMD_GT}) push_cell(0);
				end else begin
					b = pop_cell();
					a = pop_cell();
					case (w.command)
						CMD_ADD: c = a + b;
						CMD_SUB: c = a - b;
						CMD_MUL: c = a * b;
						CMD_DIV, CMD_MOD: begin
							if (b == 0) begin
								st = ST_DIVZ;
								c = 0;
							end else c = (w.command == CMD_DIV) ? a / b : a % b;
						end
						CMD_EQ: c = {31'd0, a == b};
						CMD_LT: c = {31'd0, a < b};
						default: c = {31'd0, a > b};
					endcase
					push_cell(c);
				end
			end
			CMD_INC, CMD_DEC: begin
				if (depth < 1) st = ST_UNDER;
				else cells[depth-1] += (w.command == CMD_INC) ? 32'd1 : 32'hFFFF_FFFF;
			end
			CMD_ZEQ: begin
				if (depth < 1) begin
					st = ST_UNDER;
					push_cell(0);
				end else cells[depth-1] = {31'd0, cells[depth-1] == 0};
			end
			CMD_FETCH, CMD_CFETCH: begin
				if (depth < 1) begin
					st = ST_UNDER;
					push_cell(0);
				end else begin
					a = pop_cell();
					c = 0;
					if (w.command == CMD_FETCH && {32'd0, a} + 64'd4 <= DICT_BYTES)
						c = {dict[a+3], dict[a+2], dict[a+1], dict[a]};
					else if (w.command == CMD_CFETCH && a < DICT_BYTES)
						c = {24'd0, dict[a]};
					else st = ST_OOB;
					push_cell(c);
				end
			end
			CMD_STORE, CMD_CSTORE: begin
				if (depth < 2) st = ST_UNDER;
				else begin
					a = pop_cell();
					b = pop_cell();
					if (w.command == CMD_STORE && {32'd0, a} + 64'd4 <= DICT_BYTES) begin
						dict[a] = b[7:0];
						dict[a+1] = b[15:8];
						dict[a+2] = b[23:16];
						dict[a+3] = b[31:24];
					end else if (w.command == CMD_CSTORE && a < DICT_BYTES)
						dict[a] = b[7:0];
					else st = ST_OOB;
				end
			end
			CMD_ZBRANCH: begin
				if (depth < 1) st = ST_UNDER;
				else br = pop_cell() == 0;
			end
			default: ;
		endcase
		r.top_value = (depth > 0) ? cells[depth-1] : 32'd0;
		r.stack_depth = depth[6:0];
		r.status = st;
		r.branch_taken = br;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_word_t want;
		if (!arst_n) begin
			depth = 0;
			for (int i = 0; i < DICT_BYTES; i++) dict[i] = 8'd0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				expected_results.push_back(execute_command(cmd_word));
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result top_value", res_word.top_value, 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (res_word.top_value !== want.top_value)
						report_mismatch("top_value", res_word.top_value, want.top_value);
					if (res_word.stack_depth !== want.stack_depth)
						report_mismatch("stack_depth", res_word.stack_depth, want.stack_depth);
					if (res_word.status !== want.status)
						report_mismatch("status", res_word.status, want.status);
					if (res_word.branch_taken !== want.branch_taken)
						report_mismatch("branch_taken", res_word.branch_taken,
							want.branch_taken);
				end
			end
		end
	end

endmodule

// ===== tb/forth_data_stack_alu_top_test.sv =====
`timescale 1ns / 1ps
module forth_data_stack_alu_top_test;
	import fdsa_pkg::*;

	localparam int RANDOM_WORDS = 500;
	localparam int CYCLE_LIMIT  = 400000;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_word_t cmd_word;
	logic      res_valid;
	logic      res_stall;
	res_word_t res_word;
	int        fail_count;
	int        pending_count;
	int        cycle_count;
	int        words_sent;
	int        tail;
	logic      quiet_phase;

	forth_data_stack_alu_top u_top (.*);
	forth_data_stack_alu_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("forth_data_stack_alu_top: mismatch");
				$finish;
			end
		end
	end

	// result side stalls at random
	initial begin
		int gap;
		res_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			gap = quiet_phase ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	task automatic send_word(input cmd_t c, input logic [31:0] v);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= '{command: c, push_value: v};
		do @(posedge clk); while (cmd_stall);
		words_sent++;
	endtask

	task automatic send_raw(input logic [4:0] c, input logic [31:0] v);
		send_word(cmd_t'(c), v);
	endtask

	function automatic logic [31:0] random_addr();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'd4096 - $urandom_range(0, 6);
			default: return $urandom_range(0, 63);
		endcase
	endfunction

	initial begin
		int n;
		cmd_t c;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_word = '0;
		quiet_phase = 1'b0;
		words_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty stack cases, then extremes
		send_word(CMD_DROP, 0);
		send_word(CMD_ADD, 0);
		send_word(CMD_EQ, 0);
		send_word(CMD_FETCH, 0);
		send_word(CMD_ZBRANCH, 0);
		send_word(CMD_ZBRANCH, 0);
		send_word(CMD_PUSH, 32'hFFFF_FFFF);
		send_word(CMD_INC, 0);
		send_word(CMD_DEC, 0);
		send_word(CMD_PUSH, 32'd0);
		send_word(CMD_DIV, 0);
		send_word(CMD_PUSH, 32'hDEAD_BEEF);
		send_word(CMD_PUSH, 32'd4092);
		send_word(CMD_STORE, 0);
		send_word(CMD_PUSH, 32'd4093);
		send_word(CMD_FETCH, 0);
		send_word(CMD_PUSH, 32'd4095);
		send_word(CMD_CFETCH, 0);
		send_word(CMD_PUSH, 32'd4096);
		send_word(CMD_CSTORE, 0);
		send_raw(5'd31, 32'h5555_AAAA);
		send_raw(5'd22, 0);
		quiet_phase = 1'b1;
		for (int i = 0; i < 66; i++) send_word(CMD_DUP, 0);
		send_word(CMD_OVER, 0);
		send_word(CMD_PUSH, 1);
		quiet_phase = 1'b0;
		for (int i = 0; i < 66; i++) send_word(CMD_DROP, 0);

		// random: mostly sensible stack programs around small depths
		n = 0;
		while (n < RANDOM_WORDS) begin
			if ($urandom_range(0, 30) == 0) quiet_phase = ~quiet_phase;
			case ($urandom_range(0, 9))
				0, 1, 2: send_word(CMD_PUSH, $urandom_range(0, 3) == 0 ?
					$urandom_range(0, 2) : $urandom);
				3: send_word(CMD_PUSH, random_addr());
				4: begin
					send_word(CMD_PUSH, $urandom);
					send_word(CMD_PUSH, random_addr());
					send_word($urandom_range(0, 1) ? CMD_STORE : CMD_CSTORE, 0);
					send_word(CMD_PUSH, random_addr());
					send_word($urandom_range(0, 1) ? CMD_FETCH : CMD_CFETCH, 0);
					n += 4;
				end
				5: send_raw(5'($urandom_range(22, 31)), $urandom);
				default: begin
					c = cmd_t'($urandom_range(1, 21));
					send_word(c, $urandom);
				end
			endcase
			n++;
		end
		cmd_valid <= 1'b0;
		quiet_phase = 1'b0;

		tail = 0;
		while ((pending_count != 0 || tail < 200) && tail < 20000) begin
			@(posedge clk);
			if (pending_count == 0) tail++;
		end
		$display("sent %0d command words, all commands incl. empty, full and bounds cases",
			words_sent);
		if (fail_count == 0 && pending_count == 0)
			$display("forth_data_stack_alu_top: match");
		else
			$display("forth_data_stack_alu_top: mismatch");
		$finish;
	end

endmodule
